// ----- hdl/mmba_pkg.sv -----
// ----------------------------------------------------------------------------
// mmba_pkg - shared types and constants of the mean/max blend aggregator
// Payload structs, configuration indexes, sequencer states and widths.
// ----------------------------------------------------------------------------
`default_nettype none

package mmba_pkg;

    // Sample width is fixed by the payload format (Q16.8).
    localparam int SAMPLE_BITS  = 24;
    localparam int C_COUNT_BITS = 16;
    localparam int WEIGHT_BITS  = 9;
    localparam int CFG_IDX_BITS = 2;

    // Full scale of the fixed-mode weight (units of 1/256).
    localparam logic [WEIGHT_BITS-1:0] WEIGHT_ONE = WEIGHT_BITS'(256);
    localparam logic [WEIGHT_BITS-1:0] WEIGHT_RESET = WEIGHT_BITS'(128);

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_AUTO_WEIGHT = 2'd0,
        CFG_MEAN_WEIGHT = 2'd1
    } t_cfg_idx;

    typedef struct packed {
        logic                    auto_weight;
        logic [WEIGHT_BITS-1:0]  mean_weight;
    } t_cfg;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          sample_missing;
        logic                          start_new;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] blended;
        logic                          blended_missing;
        logic                          count_saturated;
    } t_out_item;

    // Result handed from the blend unit to the sequencer.
    typedef struct packed {
        logic                          done;
        logic signed [SAMPLE_BITS-1:0] blended;
        logic                          missing;
    } t_blend_res;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_BLEND,
        ST_DONE
    } t_state;

endpackage

`default_nettype wire

// ----- hdl/mmba_divider.sv -----
// ----------------------------------------------------------------------------
// mmba_divider - serial restoring divider
// Unsigned sum magnitude over count, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mmba_divider
    import mmba_pkg::*;
#(
    parameter int COUNT_BITS = C_COUNT_BITS
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_start,
    input  wire logic [SAMPLE_BITS+COUNT_BITS-1:0]   i_dividend,
    input  wire logic [COUNT_BITS-1:0]               i_divisor,
    output logic                                     o_done,
    output logic [SAMPLE_BITS-1:0]                   o_quotient
);

    localparam int DVD_W = SAMPLE_BITS + COUNT_BITS;
    localparam int CNT_W = $clog2(SAMPLE_BITS);

    logic                    r_busy;
    logic                    r_done;
    logic [CNT_W-1:0]        r_cnt;
    logic [COUNT_BITS-1:0]   r_rem;
    logic [COUNT_BITS-1:0]   r_dvs;
    logic [SAMPLE_BITS-1:0]  r_dvd;
    logic [SAMPLE_BITS-1:0]  r_quo;

    logic [COUNT_BITS:0]     trial;
    logic [COUNT_BITS:0]     diff;
    logic                    fits;

    // The top bits of the dividend are below the divisor, so the quotient fits.
    assign trial = {r_rem, r_dvd[SAMPLE_BITS-1]};
    assign fits  = (trial >= {1'b0, r_dvs});
    assign diff  = trial - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(SAMPLE_BITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_dividend[DVD_W-1:SAMPLE_BITS];
            r_dvd <= i_dividend[SAMPLE_BITS-1:0];
            r_dvs <= i_divisor;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= fits ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
            r_dvd <= {r_dvd[SAMPLE_BITS-2:0], 1'b0};
            r_quo <= {r_quo[SAMPLE_BITS-2:0], fits};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

// ----- hdl/mmba_blend.sv -----
// ----------------------------------------------------------------------------
// mmba_blend - mean/max blend unit
// Two-step weighted sum on one shared multiplier, or the ratio-based choice.
// ----------------------------------------------------------------------------
`default_nettype none

module mmba_blend
    import mmba_pkg::*;
(
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire t_cfg                          i_cfg,
    input  wire logic signed [SAMPLE_BITS-1:0] i_mean,
    input  wire logic signed [SAMPLE_BITS-1:0] i_max,
    output t_blend_res                         o_res
);

    localparam int PROD_W = SAMPLE_BITS + WEIGHT_BITS + 1;
    localparam int CMP_W  = SAMPLE_BITS + 4;

    logic                          r_busy;
    logic                          r_second;
    logic                          r_done;
    logic                          r_auto;
    logic [WEIGHT_BITS-1:0]        r_w;
    logic signed [SAMPLE_BITS-1:0] r_mean;
    logic signed [SAMPLE_BITS-1:0] r_max;
    logic signed [PROD_W-1:0]      r_acc;
    logic signed [SAMPLE_BITS-1:0] r_blended;
    logic                          r_missing;

    logic [WEIGHT_BITS-1:0]        w_sat;
    logic signed [SAMPLE_BITS-1:0] op_a;
    logic [WEIGHT_BITS-1:0]        op_b;
    logic signed [PROD_W-1:0]      a_ext;
    logic signed [PROD_W-1:0]      b_ext;
    logic signed [PROD_W-1:0]      prod;
    logic signed [PROD_W-1:0]      wsum;

    logic signed [SAMPLE_BITS:0]   mean_x;
    logic signed [SAMPLE_BITS:0]   max_x;
    logic signed [SAMPLE_BITS:0]   a_n;
    logic signed [SAMPLE_BITS:0]   m_n;
    logic signed [CMP_W-1:0]       a4;
    logic signed [CMP_W-1:0]       m4;
    logic signed [CMP_W-1:0]       a5;
    logic signed [CMP_W-1:0]       m2;
    logic signed [CMP_W-1:0]       m3;
    logic signed [SAMPLE_BITS:0]   pair;
    logic signed [SAMPLE_BITS:0]   pair_adj;
    logic signed [SAMPLE_BITS-1:0] half;

    logic signed [SAMPLE_BITS-1:0] n_blended;
    logic                          n_missing;

    assign w_sat = (i_cfg.mean_weight > WEIGHT_ONE) ? WEIGHT_ONE : i_cfg.mean_weight;

    // Shared multiplier: mean*w first, then max*(256-w).
    assign op_a  = r_second ? r_max : r_mean;
    assign op_b  = r_second ? (WEIGHT_ONE - r_w) : r_w;
    assign a_ext = {{(PROD_W-SAMPLE_BITS){op_a[SAMPLE_BITS-1]}}, op_a};
    assign b_ext = {{(PROD_W-WEIGHT_BITS){1'b0}}, op_b};
    assign prod  = a_ext * b_ext;
    assign wsum  = r_acc + prod;

    // Ratio test against 0.4 and 0.6 with the divisor made positive.
    assign mean_x = {r_mean[SAMPLE_BITS-1], r_mean};
    assign max_x  = {r_max[SAMPLE_BITS-1], r_max};
    assign a_n    = r_max[SAMPLE_BITS-1] ? -mean_x : mean_x;
    assign m_n    = r_max[SAMPLE_BITS-1] ? -max_x : max_x;
    assign a4     = {{(CMP_W-SAMPLE_BITS-1){a_n[SAMPLE_BITS]}}, a_n};
    assign m4     = {{(CMP_W-SAMPLE_BITS-1){m_n[SAMPLE_BITS]}}, m_n};
    assign a5     = (a4 <<< 2) + a4;
    assign m2     = m4 <<< 1;
    assign m3     = m2 + m4;

    // Midpoint truncated toward zero: bias negative sums up by one.
    assign pair     = mean_x + max_x;
    assign pair_adj = pair[SAMPLE_BITS] ? (pair + (SAMPLE_BITS+1)'(1)) : pair;
    assign half     = pair_adj[SAMPLE_BITS:1];

    always_comb begin
        n_blended = '0;
        n_missing = 1'b0;
        if (!r_auto) begin
            n_blended = wsum[SAMPLE_BITS+7:8];
        end else if (r_max == '0) begin
            if (r_mean == '0) begin
                n_missing = 1'b1;
            end else if (r_mean[SAMPLE_BITS-1]) begin
                n_blended = r_mean;
            end else begin
                n_blended = r_max;
            end
        end else if (a5 < m2) begin
            n_blended = r_mean;
        end else if (a5 <= m3) begin
            n_blended = half;
        end else begin
            n_blended = r_max;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_second <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy   <= 1'b1;
                r_second <= 1'b0;
            end else if (r_busy) begin
                r_second <= 1'b1;
                if (r_second) begin
                    r_busy   <= 1'b0;
                    r_second <= 1'b0;
                    r_done   <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_auto <= i_cfg.auto_weight;
            r_w    <= w_sat;
            r_mean <= i_mean;
            r_max  <= i_max;
        end else if (r_busy && !r_second) begin
            r_acc <= prod;
        end
        if (r_busy && r_second) begin
            r_blended <= n_blended;
            r_missing <= n_missing;
        end
    end

    assign o_res.done    = r_done;
    assign o_res.blended = r_blended;
    assign o_res.missing = r_missing;

endmodule

`default_nettype wire

// ----- hdl/mean_max_blend_aggregator.sv -----
// ----------------------------------------------------------------------------
// mean_max_blend_aggregator - running mean/max blend of Q16.8 samples
//
// Input channel (i_in_valid / o_in_stall / i_in_data): one sample per transfer
// with a missing flag and a restart flag. Each transfer updates sum, count
// and maximum and yields exactly one result transfer on the output channel
// (o_out_valid / i_out_stall / o_out_data).
// Configuration channel (i_cfg_valid / o_cfg_ready): index 0 selects auto
// mode, index 1 sets the fixed-mode mean weight; other indexes are dropped.
// Write only while the block is idle.
// Sequence: with a nonzero count the result reaches the output register after
// SAMPLE_BITS serial divider steps, one mean bit each, a blend load, two
// shared-multiplier steps, a result capture and the output load; only then
// does the block take the next item. An empty accumulator skips the divider
// and the blend unit, and its result goes straight to the output load.
// Reset clears the accumulator, sets auto mode and a weight of 128.
// A stalled output holds its result; the block then keeps the input stalled
// only until the waiting result can move into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mean_max_blend_aggregator
    import mmba_pkg::*;
#(
    parameter int COUNT_BITS = C_COUNT_BITS
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    // sample input
    input  wire logic                    i_in_valid,
    output logic                         o_in_stall,
    input  wire t_in_item                i_in_data,
    // result output
    output logic                         o_out_valid,
    input  wire logic                    i_out_stall,
    output t_out_item                    o_out_data,
    // configuration writes
    input  wire logic                    i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  wire logic [WEIGHT_BITS-1:0]  i_cfg_data
);

    localparam int SUM_W = SAMPLE_BITS + COUNT_BITS;
    localparam logic [COUNT_BITS-1:0] COUNT_FULL = '1;
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    // Sequencer
    t_state r_state;
    t_state n_state;

    // Configuration
    t_cfg r_cfg;

    // Accumulator
    logic signed [SUM_W-1:0]       r_sum;
    logic [COUNT_BITS-1:0]         r_count;
    logic signed [SAMPLE_BITS-1:0] r_max;
    logic                          r_neg;
    logic                          r_sat;

    logic signed [SUM_W-1:0]       n_sum;
    logic [COUNT_BITS-1:0]         n_count;
    logic signed [SAMPLE_BITS-1:0] n_max;
    logic                          n_sat;

    // Result and output stage
    t_out_item r_res;
    t_out_item r_out;
    logic      r_out_valid;

    logic in_accept;
    logic out_accept;
    logic div_start;
    logic load_out;

    logic [SUM_W-1:0]              dividend;
    logic                          div_done;
    logic [SAMPLE_BITS-1:0]        quotient;
    logic signed [SAMPLE_BITS:0]   mean_wide;
    logic signed [SAMPLE_BITS-1:0] mean;
    t_blend_res                    blend;

    assign in_accept  = i_in_valid && !o_in_stall;
    assign out_accept = r_out_valid && !i_out_stall;

    // Restart first, then fold in a present sample unless the count is full.
    always_comb begin
        n_sum   = i_in_data.start_new ? '0 : r_sum;
        n_count = i_in_data.start_new ? '0 : r_count;
        n_max   = i_in_data.start_new ? SAMPLE_MIN : r_max;
        n_sat   = 1'b0;
        if (!i_in_data.sample_missing) begin
            if (n_count == COUNT_FULL) begin
                n_sat = 1'b1;
            end else begin
                n_count = n_count + COUNT_BITS'(1);
                n_sum   = n_sum + {{COUNT_BITS{i_in_data.sample[SAMPLE_BITS-1]}},
                                   i_in_data.sample};
                if (i_in_data.sample > n_max) begin
                    n_max = i_in_data.sample;
                end
            end
        end
    end

    // Divide the magnitude; restore the sign afterwards (truncation toward zero).
    assign dividend  = n_sum[SUM_W-1] ? SUM_W'(-n_sum) : SUM_W'(n_sum);
    assign mean_wide = r_neg ? -$signed({1'b0, quotient}) : $signed({1'b0, quotient});
    assign mean      = mean_wide[SAMPLE_BITS-1:0];

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    n_state = (n_count != '0) ? ST_DIV : ST_DONE;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    n_state = ST_BLEND;
                end
            end
            ST_BLEND: begin
                if (blend.done) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        o_in_stall = 1'b1;
        div_start  = 1'b0;
        load_out   = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                div_start  = i_in_valid && (n_count != '0);
            end
            ST_DONE: begin
                load_out = !r_out_valid || !i_out_stall;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Configuration register file; unknown indexes are dropped.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.auto_weight <= 1'b1;
            r_cfg.mean_weight <= WEIGHT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_AUTO_WEIGHT: r_cfg.auto_weight <= i_cfg_data[0];
                CFG_MEAN_WEIGHT: r_cfg.mean_weight <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Accumulator state advances on each input transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= '0;
            r_count <= '0;
            r_max   <= SAMPLE_MIN;
        end else if (in_accept) begin
            r_sum   <= n_sum;
            r_count <= n_count;
            r_max   <= n_max;
        end
    end

    // Result assembly: empty accumulator gives a missing result at once.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_neg                 <= n_sum[SUM_W-1];
            r_sat                 <= n_sat;
            r_res.blended         <= '0;
            r_res.blended_missing <= 1'b1;
            r_res.count_saturated <= n_sat;
        end else if (blend.done) begin
            r_res.blended         <= blend.missing ? '0 : blend.blended;
            r_res.blended_missing <= blend.missing;
            r_res.count_saturated <= r_sat;
        end
    end

    // Output register: hold while stalled, refill from the finished result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (out_accept) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out <= r_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    mmba_divider #(
        .COUNT_BITS (COUNT_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (dividend),
        .i_divisor  (n_count),
        .o_done     (div_done),
        .o_quotient (quotient)
    );

    mmba_blend u_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_done),
        .i_cfg   (r_cfg),
        .i_mean  (mean),
        .i_max   (r_max),
        .o_res   (blend)
    );

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench - self-checking bench for the mean/max blend aggregator
// Drives samples through the input channel and writes the configuration
// between phases. Each transfer is predicted by a local model of sum, count
// and maximum, and every result is checked field by field in order.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench
    import mmba_pkg::*;
;

    // Count width of the block as delivered.
    localparam int CNT_BITS      = C_COUNT_BITS;
    localparam int N_PHASES      = 8;
    localparam int PHASE_ITEMS   = 144;
    localparam int DRAIN_GAP     = 4;
    localparam int SETTLE_CYCLES = SAMPLE_BITS + 12;
    localparam int CYCLE_LIMIT   = 300000;

    localparam logic signed [SAMPLE_BITS-1:0] SMP_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic signed [SAMPLE_BITS-1:0] SMP_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic [CNT_BITS-1:0]           CNT_FULL = '1;
    localparam longint                        W_FULL   = WEIGHT_ONE;

    // Indexes past the register list; writes to them must be dropped.
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_3 = 2'd3;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                    in_valid = 1'b0;
    logic                    in_stall;
    t_in_item                in_data = '0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    t_out_item               out_data;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_IDX_BITS-1:0] cfg_index = CFG_AUTO_WEIGHT;
    logic [WEIGHT_BITS-1:0]  cfg_data = '0;

    // Local copy of the configuration and the accumulator.
    logic                                   cfg_auto = 1'b1;
    logic [WEIGHT_BITS-1:0]                 cfg_weight = WEIGHT_RESET;
    logic signed [SAMPLE_BITS+CNT_BITS-1:0] acc_sum = '0;
    logic [CNT_BITS-1:0]                    acc_count = '0;
    logic signed [SAMPLE_BITS-1:0]          acc_max = SMP_MIN;

    t_in_item  sample_queue[$];
    t_out_item blend_queue[$];

    bit idle_en = 1'b1;
    int in_gap_left = 0;
    int stall_left = 0;
    int cycle_count = 0;
    int err_count = 0;
    int n_sent = 0;
    int n_checked = 0;
    int n_dropped = 0;
    int n_empty = 0;
    int n_cfg_writes = 0;

    mean_max_blend_aggregator #(
        .COUNT_BITS(CNT_BITS)
    ) DUT (
        .i_clk(clk),
        .i_rst_n(rst_n),
        .i_in_valid(in_valid),
        .o_in_stall(in_stall),
        .i_in_data(in_data),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data(out_data),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index),
        .i_cfg_data(cfg_data)
    );

    always #6 clk = ~clk;

    // Watchdog: a hung handshake ends the run here.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("testbench failed");
            $finish;
        end
    end

    task automatic report_error(input string msg);
        err_count++;
        if (err_count <= 40)
            $display("[cycle %0d] mismatch: %s", cycle_count, msg);
    endtask

    // Update sum, count and maximum for one accepted sample and queue the
    // blended value it must produce.
    task automatic predict_blend(input t_in_item it);
        logic signed [SAMPLE_BITS-1:0] smp;
        longint sum_v, cnt_v, mean_v, max_v, num, den, w, blend;
        t_out_item res;
        smp = it.sample;
        res = '0;
        res.blended_missing = 1'b1;
        blend = 0;
        if (it.start_new) begin
            acc_sum = '0;
            acc_count = '0;
            acc_max = SMP_MIN;
        end
        if (!it.sample_missing) begin
            if (acc_count == CNT_FULL) begin
                // Full count: drop the sample and flag it.
                res.count_saturated = 1'b1;
                n_dropped++;
            end else begin
                acc_count = acc_count + 1'b1;
                acc_sum = acc_sum + smp;
                if (smp > acc_max)
                    acc_max = smp;
            end
        end
        if (acc_count != 0) begin
            sum_v = acc_sum;
            cnt_v = acc_count;
            mean_v = sum_v / cnt_v;
            max_v = acc_max;
            if (!cfg_auto) begin
                // Weights past full scale clamp to full scale.
                w = (cfg_weight > WEIGHT_ONE) ? W_FULL : longint'(cfg_weight);
                blend = (mean_v * w + max_v * (W_FULL - w)) >>> 8;
                res.blended_missing = 1'b0;
            end else if (max_v == 0) begin
                // Zero maximum: the sign of the mean decides, zero is missing.
                if (mean_v > 0) begin
                    blend = max_v;
                    res.blended_missing = 1'b0;
                end else if (mean_v < 0) begin
                    blend = mean_v;
                    res.blended_missing = 1'b0;
                end
            end else begin
                // Compare mean/max with 2/5 and 3/5 on a positive divisor.
                num = mean_v;
                den = max_v;
                if (den < 0) begin
                    num = -num;
                    den = -den;
                end
                if (5 * num < 2 * den)
                    blend = mean_v;
                else if (5 * num <= 3 * den)
                    blend = (mean_v + max_v) / 2;
                else
                    blend = max_v;
                res.blended_missing = 1'b0;
            end
        end
        if (res.blended_missing) begin
            blend = 0;
            n_empty++;
        end
        res.blended = SAMPLE_BITS'(blend);
        blend_queue.push_back(res);
    endtask

    // Input driver: hold the payload while stalled, advance after a transfer,
    // and insert random idle bursts when idling is enabled.
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            in_gap_left = 0;
            acc_sum = '0;
            acc_count = '0;
            acc_max = SMP_MIN;
        end else begin
            if (in_valid && !in_stall) begin
                predict_blend(in_data);
                n_sent++;
            end
            if (!in_valid || !in_stall) begin
                if (in_gap_left > 0) begin
                    in_valid <= 1'b0;
                    in_gap_left--;
                end else if (idle_en && $urandom_range(0, 3) == 0) begin
                    in_valid <= 1'b0;
                    in_gap_left = $urandom_range(0, 2);
                end else if (sample_queue.size() != 0) begin
                    in_valid <= 1'b1;
                    in_data <= sample_queue.pop_front();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Output monitor: check each result transfer against the oldest
    // prediction and stall the output in random bursts.
    always @(posedge clk) begin : monitor
        t_out_item want;
        if (!rst_n) begin
            out_stall <= 1'b0;
            stall_left = 0;
        end else begin
            if (out_valid && !out_stall) begin
                if (blend_queue.size() == 0) begin
                    report_error("result transfer with no prediction pending");
                end else begin
                    want = blend_queue.pop_front();
                    n_checked++;
                    if (out_data.blended !== want.blended)
                        report_error($sformatf("blended got %0d want %0d",
                            $signed(out_data.blended), $signed(want.blended)));
                    if (out_data.blended_missing !== want.blended_missing)
                        report_error($sformatf("blended_missing got %b want %b",
                            out_data.blended_missing, want.blended_missing));
                    if (out_data.count_saturated !== want.count_saturated)
                        report_error($sformatf("count_saturated got %b want %b",
                            out_data.count_saturated, want.count_saturated));
                end
            end
            if (stall_left > 0) begin
                out_stall <= 1'b1;
                stall_left--;
            end else if (idle_en && $urandom_range(0, 5) == 0) begin
                out_stall <= 1'b1;
                stall_left = $urandom_range(0, 2);
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    task automatic push_sample(input logic signed [SAMPLE_BITS-1:0] s, input logic miss,
                               input logic restart);
        t_in_item it;
        it.sample = s;
        it.sample_missing = miss;
        it.start_new = restart;
        sample_queue.push_back(it);
    endtask

    // Write one register and mirror it once the transfer completes.
    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [WEIGHT_BITS-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        n_cfg_writes++;
        case (idx)
            CFG_AUTO_WEIGHT: cfg_auto = val[0];
            CFG_MEAN_WEIGHT: cfg_weight = val;
            default: ;
        endcase
    endtask

    // Block until every queued sample went in and every result came out.
    task automatic wait_drained();
        do @(negedge clk);
        while (sample_queue.size() != 0 || in_valid || blend_queue.size() != 0);
        repeat (DRAIN_GAP) @(negedge clk);
    endtask

    function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
        logic signed [SAMPLE_BITS-1:0] v;
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 4))
                    0: v = SMP_MIN;
                    1: v = SMP_MAX;
                    2: v = '0;
                    3: v = 1;
                    default: v = '1;
                endcase
            end
            // small values land on the 2/5 and 3/5 ratio boundaries often
            1, 2, 3: v = SAMPLE_BITS'(int'($urandom_range(0, 40)) - 20);
            4, 5: v = SAMPLE_BITS'(int'($urandom_range(0, 8191)) - 4096);
            default: v = SAMPLE_BITS'($urandom());
        endcase
        return v;
    endfunction

    // Runs that open with a restart, mixing short and long accumulations.
    task automatic gen_runs(input int n_items);
        int left, len, k;
        left = n_items;
        while (left > 0) begin
            if ($urandom_range(0, 3) == 0)
                len = $urandom_range(30, 50);
            else
                len = $urandom_range(1, 12);
            if (len > left)
                len = left;
            for (k = 0; k < len; k++)
                push_sample(rand_sample(), $urandom_range(0, 7) == 0,
                            k == 0 || $urandom_range(0, 24) == 0);
            left -= len;
        end
    endtask

    initial begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        // Reset settings: auto mode, weight 128.
        push_sample(123, 1'b1, 1'b0);           // empty accumulator
        push_sample(0, 1'b0, 1'b1);             // zero max and zero mean
        push_sample(256, 1'b0, 1'b0);           // ratio 1/2 blends
        push_sample(SMP_MAX, 1'b1, 1'b0);       // missing sample keeps state
        push_sample(SMP_MIN, 1'b0, 1'b1);
        push_sample(SMP_MAX, 1'b0, 1'b0);       // extremes cancel to zero mean
        push_sample(0, 1'b0, 1'b1);
        push_sample(-100, 1'b0, 1'b0);          // zero max, negative mean
        push_sample(5, 1'b0, 1'b1);
        push_sample(-1, 1'b0, 1'b0);            // ratio exactly 2/5
        push_sample(5, 1'b0, 1'b1);
        push_sample(1, 1'b0, 1'b0);             // ratio exactly 3/5
        push_sample(5, 1'b0, 1'b1);
        push_sample(3, 1'b0, 1'b0);             // ratio above 3/5
        push_sample(-7, 1'b0, 1'b1);
        push_sample(-3, 1'b0, 1'b0);            // negative maximum
        push_sample(42, 1'b1, 1'b1);            // restart with nothing present
        wait_drained();

        // Fixed mode; upper data bits must not leak into the mode bit.
        write_reg(CFG_AUTO_WEIGHT, 9'h1FE);
        write_reg(CFG_MEAN_WEIGHT, 9'd0);
        push_sample(-1000, 1'b0, 1'b1);
        push_sample(3000, 1'b0, 1'b0);
        wait_drained();
        write_reg(CFG_MEAN_WEIGHT, WEIGHT_ONE);
        push_sample(7, 1'b0, 1'b1);
        push_sample(-2, 1'b0, 1'b0);
        wait_drained();
        // Weight above full scale, then writes to unused indexes.
        write_reg(CFG_MEAN_WEIGHT, 9'h1FF);
        write_reg(CFG_SPARE_2, 9'h001);
        write_reg(CFG_SPARE_3, 9'h0AA);
        push_sample(-5, 1'b0, 1'b1);
        push_sample(2, 1'b0, 1'b0);
        wait_drained();
        write_reg(CFG_MEAN_WEIGHT, 9'd77);
        push_sample(-9, 1'b0, 1'b1);
        push_sample(4, 1'b0, 1'b0);
        push_sample(-9, 1'b0, 1'b1);
        push_sample(-13, 1'b0, 1'b0);           // floor of a negative blend

        // Random phases over several settings; the last one runs flat out.
        for (int ph = 0; ph < N_PHASES; ph++) begin
            wait_drained();
            case (ph)
                0: write_reg(CFG_AUTO_WEIGHT, 9'd1);
                1: begin
                    write_reg(CFG_AUTO_WEIGHT, 9'd0);
                    write_reg(CFG_MEAN_WEIGHT, 9'd0);
                end
                2: write_reg(CFG_MEAN_WEIGHT, WEIGHT_ONE);
                3: write_reg(CFG_MEAN_WEIGHT, WEIGHT_BITS'($urandom_range(1, 255)));
                4: write_reg(CFG_AUTO_WEIGHT, 9'd1);
                5: begin
                    write_reg(CFG_AUTO_WEIGHT, 9'd0);
                    write_reg(CFG_MEAN_WEIGHT, WEIGHT_BITS'($urandom_range(257, 511)));
                end
                6: begin
                    write_reg(CFG_MEAN_WEIGHT, WEIGHT_BITS'($urandom_range(0, 256)));
                    write_reg(CFG_SPARE_3, WEIGHT_BITS'($urandom()));
                end
                default: write_reg(CFG_AUTO_WEIGHT, 9'd1);
            endcase
            idle_en = (ph != 4) && (ph != N_PHASES - 1);
            @(negedge clk);
            gen_runs(PHASE_ITEMS);
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);

        $display("covered %0d samples and %0d checked results, %0d dropped on a full count,",
                 n_sent, n_checked, n_dropped);
        $display("%0d empty results, %0d register writes, %0d mismatches",
                 n_empty, n_cfg_writes, err_count);
        if (err_count == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule

`default_nettype wire
